FILE: rtl/core/lgvt_pkg.sv
// ----------------------------------------------------------------------------
// lgvt_pkg
// Shared constants, register indexes and item classes for the light gesture
// volume and tempo block.
// ----------------------------------------------------------------------------
package lgvt_pkg;

    localparam int DEF_SAMPLE_BITS    = 10;
    localparam int DEF_POT_MAX        = 128;
    localparam int STEP_BITS          = 8;
    localparam int PERIOD_BITS        = 16;
    localparam int CFG_DATA_BITS      = 16;
    localparam int CFG_IDX_BITS       = 3;

    localparam int LOW_RESET          = 0;
    localparam int MID_RESET          = 512;
    localparam int HIGH_RESET         = 1023;
    localparam int MIN_PERIOD_RESET   = 300;
    localparam int FIRST_PERIOD_RESET = 500;
    localparam int LOW_MARGIN         = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOW          = 3'd0,
        REG_MID          = 3'd1,
        REG_HIGH         = 3'd2,
        REG_MIN_PERIOD   = 3'd3,
        REG_FIRST_PERIOD = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ZERO,
        CLS_FULL,
        CLS_DIV
    } t_class;

endpackage

FILE: rtl/core/lgvt_front.sv
// ----------------------------------------------------------------------------
// lgvt_front
// Takes tick requests, clamps the volume sample and classifies the target
// step; forms the scaled numerator and the range for the divider.
// ----------------------------------------------------------------------------
module lgvt_front import lgvt_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int POT_MAX     = DEF_POT_MAX,
    localparam int PW         = $clog2(POT_MAX + 1),
    localparam int NW         = SAMPLE_BITS + PW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_sample_valid,
    input  logic [SAMPLE_BITS-1:0] i_volume_sample,
    input  logic [SAMPLE_BITS-1:0] i_hand_sample,
    input  logic [SAMPLE_BITS-1:0] i_low,
    input  logic [SAMPLE_BITS-1:0] i_high,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output t_class                 o_cls,
    output logic [NW-1:0]          o_num,
    output logic [SAMPLE_BITS-1:0] o_den,
    output logic [SAMPLE_BITS-1:0] o_hand
);

    logic                   r_vld;
    logic                   r_sv;
    logic [SAMPLE_BITS-1:0] r_vol;
    logic [SAMPLE_BITS-1:0] r_hand;
    logic                   load;
    logic [SAMPLE_BITS-1:0] clamped;
    logic [SAMPLE_BITS-1:0] diff;

    assign full     = r_vld && i_q_full;
    assign load     = push && !full;
    assign o_q_push = r_vld;
    assign o_hand   = r_hand;

    always_comb begin
        clamped = (r_vol > i_high) ? i_high : r_vol;
        diff    = clamped - i_low;
        o_den   = i_high - i_low;
        o_num   = NW'(diff) * NW'(POT_MAX);
        if (!r_sv) begin
            o_cls = CLS_NONE;
        end else if (clamped < i_low) begin
            o_cls = CLS_ZERO;
        end else if (i_high <= i_low) begin
            o_cls = CLS_FULL;
        end else begin
            o_cls = CLS_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (load) begin
                r_vld  <= 1'b1;
                r_sv   <= i_sample_valid;
                r_vol  <= i_volume_sample;
                r_hand <= i_hand_sample;
            end else if (!i_q_full) begin
                r_vld <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/lgvt_queue.sv
// ----------------------------------------------------------------------------
// lgvt_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module lgvt_queue import lgvt_pkg::*; #(
    parameter int WIDTH = CFG_DATA_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/lgvt_back.sv
// ----------------------------------------------------------------------------
// lgvt_back
// Runs the serial divider for the target step, slews the pot step, tracks
// the hand hysteresis and beat period, and holds the result register.
// ----------------------------------------------------------------------------
module lgvt_back import lgvt_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int POT_MAX     = DEF_POT_MAX,
    localparam int PW         = $clog2(POT_MAX + 1),
    localparam int NW         = SAMPLE_BITS + PW,
    localparam int CW         = $clog2(PW)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    output logic                   o_q_pop,
    input  t_class                 i_cls,
    input  logic [NW-1:0]          i_num,
    input  logic [SAMPLE_BITS-1:0] i_den,
    input  logic [SAMPLE_BITS-1:0] i_hand,
    input  logic [SAMPLE_BITS-1:0] i_low,
    input  logic [SAMPLE_BITS-1:0] i_mid,
    input  logic [SAMPLE_BITS-1:0] i_high,
    input  logic [PERIOD_BITS-1:0] i_min_period,
    input  logic [PERIOD_BITS-1:0] i_first_period,
    input  logic                   pop,
    output logic                   empty,
    output logic                   o_pot_write,
    output logic [STEP_BITS-1:0]   o_pot_step,
    output logic                   o_beat,
    output logic [PERIOD_BITS-1:0] o_beat_period,
    output logic                   o_hand_is_high
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} t_state;

    t_state                 r_state;
    t_class                 r_cls;
    logic [SAMPLE_BITS-1:0] r_hand;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [PW-1:0]          r_shift;
    logic [CW-1:0]          r_cnt;
    logic [STEP_BITS-1:0]   r_target;

    logic                   r_out_valid;
    logic                   r_out_write;
    logic                   r_out_beat;
    logic [STEP_BITS-1:0]   r_last_step;
    logic                   r_hand_high;
    logic                   r_seen_low;
    logic                   r_seen_high;
    logic [PERIOD_BITS-1:0] r_tick;
    logic [PERIOD_BITS-1:0] r_period;
    logic                   r_any_beat;

    logic [SAMPLE_BITS:0]   trial;
    logic                   fits;
    logic [SAMPLE_BITS-1:0] rem_next;
    logic [PW-1:0]          shift_next;
    logic [PW-1:0]          quot_sat;
    logic                   out_free;
    logic                   sample;
    logic [SAMPLE_BITS:0]   low_plus;

    logic [STEP_BITS-1:0]   n_last_step;
    logic                   n_hand_high;
    logic                   n_seen_low;
    logic                   n_seen_high;
    logic [PERIOD_BITS-1:0] n_tick;
    logic [PERIOD_BITS-1:0] n_period;
    logic [PERIOD_BITS-1:0] raw_period;
    logic                   n_any_beat;
    logic                   n_beat;

    assign out_free       = !r_out_valid || pop;
    assign o_q_pop        = (r_state == ST_IDLE) && !i_q_empty;
    assign empty          = !r_out_valid;
    assign o_pot_write    = r_out_write;
    assign o_beat         = r_out_beat;
    assign o_pot_step     = r_last_step;
    assign o_beat_period  = r_period;
    assign o_hand_is_high = r_hand_high;
    assign sample         = (r_cls != CLS_NONE);

    always_comb begin
        trial      = {r_rem, r_shift[PW-1]};
        fits       = (trial >= {1'b0, r_den});
        rem_next   = fits ? SAMPLE_BITS'(trial - {1'b0, r_den}) : trial[SAMPLE_BITS-1:0];
        shift_next = {r_shift[PW-2:0], fits};
        quot_sat   = (shift_next > PW'(POT_MAX)) ? PW'(POT_MAX) : shift_next;
    end

    always_comb begin
        low_plus    = {1'b0, i_low} + (SAMPLE_BITS + 1)'(LOW_MARGIN);
        n_last_step = r_last_step;
        n_hand_high = r_hand_high;
        n_seen_low  = r_seen_low;
        n_seen_high = r_seen_high;
        n_tick      = r_tick;
        n_period    = r_period;
        n_any_beat  = r_any_beat;
        n_beat      = 1'b0;
        raw_period  = r_any_beat ? r_tick : i_first_period;
        if (sample) begin
            if (r_target > r_last_step) begin
                n_last_step = r_last_step + 1'b1;
            end else if (r_target < r_last_step) begin
                n_last_step = r_last_step - 1'b1;
            end
            if (!r_hand_high) begin
                if ((r_hand > i_mid) && r_seen_low) begin
                    n_hand_high = 1'b1;
                    n_seen_high = 1'b0;
                    n_beat      = 1'b1;
                    n_any_beat  = 1'b1;
                    n_tick      = '0;
                    n_period    = (raw_period < i_min_period) ? i_min_period : raw_period;
                end
            end else begin
                if ((r_hand < i_mid) && r_seen_high) begin
                    n_hand_high = 1'b0;
                    n_seen_low  = 1'b0;
                end
            end
            if ({1'b0, r_hand} <= low_plus) begin
                n_seen_low = 1'b1;
            end
            if (r_hand >= i_high) begin
                n_seen_high = 1'b1;
            end
        end
        if (n_tick != '1) begin
            n_tick = n_tick + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_out_write <= 1'b0;
            r_out_beat  <= 1'b0;
            r_last_step <= '0;
            r_hand_high <= 1'b1;
            r_seen_low  <= 1'b0;
            r_seen_high <= 1'b0;
            r_tick      <= '0;
            r_period    <= '0;
            r_any_beat  <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_cls   <= i_cls;
                        r_hand  <= i_hand;
                        r_den   <= i_den;
                        r_rem   <= i_num[NW-1:PW];
                        r_shift <= i_num[PW-1:0];
                        r_cnt   <= '0;
                        if (i_cls == CLS_DIV) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_target <= (i_cls == CLS_FULL) ? STEP_BITS'(POT_MAX) : '0;
                            r_state  <= ST_DONE;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem   <= rem_next;
                    r_shift <= shift_next;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CW'(PW - 1)) begin
                        r_target <= STEP_BITS'(quot_sat);
                        r_state  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_write <= sample;
                        r_out_beat  <= n_beat;
                        r_last_step <= n_last_step;
                        r_hand_high <= n_hand_high;
                        r_seen_low  <= n_seen_low;
                        r_seen_high <= n_seen_high;
                        r_tick      <= n_tick;
                        r_period    <= n_period;
                        r_any_beat  <= n_any_beat;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/light_gesture_volume_and_tempo_top.sv
// ----------------------------------------------------------------------------
// light_gesture_volume_and_tempo_top
// One request per timer tick. Tick requests enter through push/full and are
// taken when push is high and full is low. Each request gives exactly one
// result, shown on the output ports while empty is low and taken when pop is
// high and empty is low. pot_step, beat_period and hand_is_high always show
// the current held state; pot_write and beat mark what this tick did.
// A request is registered in the input stage, then passes a two-entry
// queue to the divider and is registered as the result; up to five
// requests can be held while pop stays low, and full rises once five are
// held. New requests are taken while the shift-subtract divider forms the
// target step one quotient bit per cycle; ticks without a sample, or with
// a zero or full step, skip it. Configuration writes take effect at once;
// the user must make them only while no request is in flight, which the
// block does not enforce. Reset clears the held state: step 0, hand high,
// no beat yet, period 0, configuration to its defaults.
// ----------------------------------------------------------------------------
module light_gesture_volume_and_tempo_top import lgvt_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int POT_MAX     = DEF_POT_MAX
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_sample_valid,
    input  logic [SAMPLE_BITS-1:0]   i_volume_sample,
    input  logic [SAMPLE_BITS-1:0]   i_hand_sample,
    input  logic                     pop,
    output logic                     empty,
    output logic                     o_pot_write,
    output logic [STEP_BITS-1:0]     o_pot_step,
    output logic                     o_beat,
    output logic [PERIOD_BITS-1:0]   o_beat_period,
    output logic                     o_hand_is_high,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int PW = $clog2(POT_MAX + 1);
    localparam int NW = SAMPLE_BITS + PW;
    localparam int QW = 2 + SAMPLE_BITS + SAMPLE_BITS + NW;

    logic [SAMPLE_BITS-1:0] r_low;
    logic [SAMPLE_BITS-1:0] r_mid;
    logic [SAMPLE_BITS-1:0] r_high;
    logic [PERIOD_BITS-1:0] r_min_period;
    logic [PERIOD_BITS-1:0] r_first_period;

    logic                   f_push;
    t_class                 f_cls;
    logic [NW-1:0]          f_num;
    logic [SAMPLE_BITS-1:0] f_den;
    logic [SAMPLE_BITS-1:0] f_hand;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [QW-1:0]          q_din;
    logic [QW-1:0]          q_dout;
    t_class                 b_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low          <= SAMPLE_BITS'(LOW_RESET);
            r_mid          <= SAMPLE_BITS'(MID_RESET);
            r_high         <= SAMPLE_BITS'(HIGH_RESET);
            r_min_period   <= PERIOD_BITS'(MIN_PERIOD_RESET);
            r_first_period <= PERIOD_BITS'(FIRST_PERIOD_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW:          r_low          <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_MID:          r_mid          <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_HIGH:         r_high         <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_MIN_PERIOD:   r_min_period   <= i_cfg_data[PERIOD_BITS-1:0];
                REG_FIRST_PERIOD: r_first_period <= i_cfg_data[PERIOD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    lgvt_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .POT_MAX     (POT_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample_valid  (i_sample_valid),
        .i_volume_sample (i_volume_sample),
        .i_hand_sample   (i_hand_sample),
        .i_low           (r_low),
        .i_high          (r_high),
        .i_q_full        (q_full),
        .o_q_push        (f_push),
        .o_cls           (f_cls),
        .o_num           (f_num),
        .o_den           (f_den),
        .o_hand          (f_hand)
    );

    assign q_din = {f_cls, f_hand, f_den, f_num};

    lgvt_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_din),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_empty (q_empty)
    );

    assign b_cls = t_class'(q_dout[QW-1 -: 2]);

    lgvt_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .POT_MAX     (POT_MAX)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_cls          (b_cls),
        .i_num          (q_dout[NW-1:0]),
        .i_den          (q_dout[NW +: SAMPLE_BITS]),
        .i_hand         (q_dout[NW + SAMPLE_BITS +: SAMPLE_BITS]),
        .i_low          (r_low),
        .i_mid          (r_mid),
        .i_high         (r_high),
        .i_min_period   (r_min_period),
        .i_first_period (r_first_period),
        .pop            (pop),
        .empty          (empty),
        .o_pot_write    (o_pot_write),
        .o_pot_step     (o_pot_step),
        .o_beat         (o_beat),
        .o_beat_period  (o_beat_period),
        .o_hand_is_high (o_hand_is_high)
    );

endmodule
